// ===== hdl/dss_pkg.sv =====
// Shared widths, register indexes, mode codes and reset values of the disk seek scheduler.
`default_nettype none

package dss_pkg;

    localparam int CYL_W  = 16;
    localparam int SUM_W  = 24;
    localparam int MODE_W = 2;

    typedef logic [CYL_W-1:0]  cyl_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [1:0]        reg_idx_t;

    // Saturation ceiling of the running seek total.
    localparam sum_t SUM_MAX = '1;

    // Scheduling mode codes; any other code serves in arrival order.
    localparam mode_t MODE_FCFS  = 2'd0;
    localparam mode_t MODE_SCAN  = 2'd1;
    localparam mode_t MODE_CSCAN = 2'd2;

    // Register indexes on the configuration port.
    localparam reg_idx_t REG_MODE       = 2'd0;
    localparam reg_idx_t REG_START_HEAD = 2'd1;
    localparam reg_idx_t REG_CYL_COUNT  = 2'd2;
    localparam reg_idx_t REG_SCAN_DIR   = 2'd3;

    // Reset values of the configuration registers.
    localparam mode_t MODE_RST      = MODE_FCFS;
    localparam cyl_t  START_RST     = 16'd0;
    localparam cyl_t  CYL_COUNT_RST = 16'd200;
    localparam logic  SCAN_DIR_RST  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/disk_seek_scheduler.sv =====
// Disk seek scheduler: request store, sorted insertion and service sequencer.
`default_nettype none

// Each request word that fits is taken into an arrival-order store and, by an insertion
// walk through a second store, into a sorted copy. The first request of a
// batch is written straight into the sorted store, and a request that finds
// the store full is dropped; any other takes a shift walk, one entry a cycle,
// through the sorted store's single read and write port. The word marked last
// starts service: the sequencer passes over the stored entries with one
// shared distance and saturating sum unit, each entry and pass taking a
// registered memory read, then the visit. First come first served makes
// one pass, the two sweep modes three passes plus one or two end stops.
// Service stalls while both output stages are full and m_ready is low.
// The block takes no request word during insertion and service; a finished
// result may still wait at the output while the next batch is collected.
module disk_seek_scheduler
    import dss_pkg::*;
#(
    parameter int MAX_REQUESTS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [15:0] s_request_cylinder,
    input  wire         s_last_request,
    // Visit channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic [15:0] m_visited_cylinder,
    output logic [23:0] m_seek_total,
    output logic        m_last_visit
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_PUT, S_START, S_RD, S_EV, S_TOP, S_JUMP, S_ZERO, S_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        PS_FCFS, PS_EQ, PS_LT_DN, PS_GT_UP, PS_GTM_UP, PS_LT_UP
    } pass_t;

    // Configuration registers.
    mode_t mode_reg;
    cyl_t  start_head_reg;
    cyl_t  cyl_count_reg;
    logic  scan_dir_reg;

    // Sequencer and datapath registers.
    state_t        state_reg, state_next;
    pass_t         pass_reg, pass_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] ins_pos_reg, ins_pos_next;
    cyl_t          val_reg, val_next;
    logic          last_reg, last_next;
    cyl_t          head_reg, head_next;
    sum_t          sum_reg, sum_next;
    logic          end_done_reg, end_done_next;
    logic          pend_valid_reg, pend_valid_next;
    cyl_t          pend_cyl_reg, pend_cyl_next;
    sum_t          pend_sum_reg, pend_sum_next;
    logic          out_valid_reg, out_valid_next;
    cyl_t          out_cyl_reg, out_cyl_next;
    sum_t          out_sum_reg, out_sum_next;
    logic          out_last_reg, out_last_next;

    // Stores and their registered read data.
    cyl_t          arr_mem [MAX_REQUESTS];
    cyl_t          srt_mem [MAX_REQUESTS];
    cyl_t          arr_rd_reg;
    cyl_t          srt_rd_reg;
    logic          arr_we;
    logic          srt_we;
    logic [AW-1:0] srt_wa;
    cyl_t          srt_wd;
    logic          ren;
    logic [AW-1:0] raddr;

    // Shared visit unit signals.
    cyl_t          top;
    cyl_t          rd_val;
    logic          merge_cond;
    cyl_t          unit_cyl;
    cyl_t          unit_diff;
    cyl_t          unit_d;
    logic [SUM_W:0] unit_wide;
    sum_t          sum_add;

    logic          cfg_we;
    logic          can_emit;
    logic          keep;
    logic          up_pass;
    logic          last_idx;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] n_m1;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RST;
            start_head_reg <= START_RST;
            cyl_count_reg  <= CYL_COUNT_RST;
            scan_dir_reg   <= SCAN_DIR_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_MODE:       mode_reg       <= pwdata[MODE_W-1:0];
                REG_START_HEAD: start_head_reg <= pwdata[CYL_W-1:0];
                REG_CYL_COUNT:  cyl_count_reg  <= pwdata[CYL_W-1:0];
                REG_SCAN_DIR:   scan_dir_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:       prdata = {30'd0, mode_reg};
            REG_START_HEAD: prdata = {16'd0, start_head_reg};
            REG_CYL_COUNT:  prdata = {16'd0, cyl_count_reg};
            REG_SCAN_DIR:   prdata = {31'd0, scan_dir_reg};
            default:        prdata = '0;
        endcase
    end

    // Highest cylinder; an empty disk size gives a top end of zero.
    assign top = (cyl_count_reg == '0) ? '0 : cyl_count_reg - 16'd1;

    // Both stores share one read address; the pass picks which data it uses.
    always_ff @(posedge aclk) begin
        if (arr_we) begin
            arr_mem[count_reg[AW-1:0]] <= s_request_cylinder;
        end
        if (srt_we) begin
            srt_mem[srt_wa] <= srt_wd;
        end
        if (ren) begin
            arr_rd_reg <= arr_mem[raddr];
            srt_rd_reg <= srt_mem[raddr];
        end
    end

    assign rd_val = (pass_reg == PS_FCFS) ? arr_rd_reg : srt_rd_reg;

    // On the upward sweep the top end stop goes in before the first request above it.
    assign merge_cond = (pass_reg == PS_GTM_UP) && (rd_val > start_head_reg) &&
                        !end_done_reg && (rd_val > top);

    // Shared unit: distance to the next stop and saturating running total.
    always_comb begin
        case (state_reg)
            S_TOP:   unit_cyl = top;
            S_ZERO:  unit_cyl = '0;
            default: unit_cyl = merge_cond ? top : rd_val;
        endcase
    end

    assign unit_diff = (unit_cyl > head_reg) ? unit_cyl - head_reg : head_reg - unit_cyl;
    assign unit_d    = (state_reg == S_JUMP) ? top : unit_diff;
    assign unit_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - CYL_W){1'b0}}, unit_d};
    assign sum_add   = unit_wide[SUM_W] ? SUM_MAX : unit_wide[SUM_W-1:0];

    // A new visit may enter the pending stage if that stage is empty or can hand on its word.
    assign can_emit = !pend_valid_reg || !out_valid_reg || m_ready;

    // Filter of the current pass.
    always_comb begin
        case (pass_reg)
            PS_FCFS:   keep = 1'b1;
            PS_EQ:     keep = (rd_val == start_head_reg);
            PS_LT_DN:  keep = (rd_val < start_head_reg);
            PS_LT_UP:  keep = (rd_val < start_head_reg);
            PS_GT_UP:  keep = (rd_val > start_head_reg);
            PS_GTM_UP: keep = (rd_val > start_head_reg);
            default:   keep = 1'b0;
        endcase
    end

    assign up_pass  = (pass_reg != PS_LT_DN);
    assign cnt_m1   = count_reg - CW'(1);
    assign n_m1     = cnt_m1[AW-1:0];
    assign last_idx = up_pass ? (idx_reg == n_m1) : (idx_reg == '0);

    // Sequencer next state.
    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ins_pos_next    = ins_pos_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        end_done_next   = end_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_cyl_next   = pend_cyl_reg;
        pend_sum_next   = pend_sum_reg;
        out_valid_next  = out_valid_reg;
        out_cyl_next    = out_cyl_reg;
        out_sum_next    = out_sum_reg;
        out_last_next   = out_last_reg;
        arr_we          = 1'b0;
        srt_we          = 1'b0;
        srt_wa          = ins_pos_reg;
        srt_wd          = val_reg;
        ren             = 1'b0;
        raddr           = idx_reg;

        // The output word leaves on its handshake.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next  = s_request_cylinder;
                    last_next = s_last_request;
                    if (count_reg < MAX_CNT) begin
                        arr_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0) begin
                            srt_we     = 1'b1;
                            srt_wa     = '0;
                            srt_wd     = s_request_cylinder;
                            state_next = s_last_request ? S_START : S_IDLE;
                        end else begin
                            ren          = 1'b1;
                            raddr        = n_m1;
                            ins_pos_next = count_reg[AW-1:0];
                            state_next   = S_INS;
                        end
                    end else begin
                        // Store full: the request is dropped.
                        state_next = s_last_request ? S_START : S_IDLE;
                    end
                end
            end

            S_INS: begin
                // Shift larger entries up one place until the new value fits.
                srt_we = 1'b1;
                if (srt_rd_reg > val_reg) begin
                    srt_wd       = srt_rd_reg;
                    ins_pos_next = ins_pos_reg - AW'(1);
                    if (ins_pos_reg == AW'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        ren   = 1'b1;
                        raddr = ins_pos_reg - AW'(1) - AW'(1);
                    end
                end else begin
                    state_next = last_reg ? S_START : S_IDLE;
                end
            end

            S_PUT: begin
                srt_we     = 1'b1;
                state_next = last_reg ? S_START : S_IDLE;
            end

            S_START: begin
                head_next     = start_head_reg;
                sum_next      = '0;
                end_done_next = 1'b0;
                idx_next      = '0;
                pass_next     = (mode_reg == MODE_SCAN || mode_reg == MODE_CSCAN) ?
                                PS_EQ : PS_FCFS;
                state_next    = S_RD;
            end

            S_RD: begin
                ren        = 1'b1;
                state_next = S_EV;
            end

            S_EV: begin
                if (merge_cond) begin
                    // Top end stop first; the same entry is looked at again.
                    if (can_emit) begin
                        end_done_next = 1'b1;
                    end
                end else if (!(keep && !can_emit)) begin
                    if (last_idx) begin
                        case (pass_reg)
                            PS_EQ: begin
                                if (mode_reg == MODE_SCAN && !scan_dir_reg) begin
                                    pass_next = PS_LT_DN;
                                    idx_next  = n_m1;
                                end else begin
                                    pass_next = PS_GTM_UP;
                                    idx_next  = '0;
                                end
                                state_next = S_RD;
                            end
                            PS_LT_DN:  state_next = scan_dir_reg ? S_FLUSH : S_ZERO;
                            PS_GTM_UP: state_next = S_TOP;
                            default:   state_next = S_FLUSH;
                        endcase
                    end else begin
                        idx_next   = up_pass ? idx_reg + AW'(1) : idx_reg - AW'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_TOP: begin
                if (end_done_reg) begin
                    if (mode_reg == MODE_SCAN) begin
                        pass_next  = PS_LT_DN;
                        idx_next   = n_m1;
                        state_next = S_RD;
                    end else begin
                        state_next = S_JUMP;
                    end
                end else if (can_emit) begin
                    end_done_next = 1'b1;
                end
            end

            S_JUMP: begin
                // Return to cylinder zero counts the full stroke.
                sum_next   = sum_add;
                head_next  = '0;
                state_next = S_ZERO;
            end

            S_ZERO: begin
                if (can_emit) begin
                    pass_next  = (mode_reg == MODE_SCAN) ? PS_GT_UP : PS_LT_UP;
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end

            S_FLUSH: begin
                // The held visit is the final one of the batch.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_cyl_next    = pend_cyl_reg;
                    out_sum_next    = pend_sum_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // A visit goes to the pending stage; the word held there moves on.
        if (can_emit && ((state_reg == S_EV && (merge_cond || keep)) ||
                         (state_reg == S_TOP && !end_done_reg) ||
                         state_reg == S_ZERO)) begin
            sum_next        = sum_add;
            head_next       = unit_cyl;
            pend_valid_next = 1'b1;
            pend_cyl_next   = unit_cyl;
            pend_sum_next   = sum_add;
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_cyl_next   = pend_cyl_reg;
                out_sum_next   = pend_sum_reg;
                out_last_next  = 1'b0;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pass_reg       <= PS_FCFS;
            count_reg      <= '0;
            idx_reg        <= '0;
            ins_pos_reg    <= '0;
            last_reg       <= 1'b0;
            head_reg       <= START_RST;
            sum_reg        <= '0;
            end_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            ins_pos_reg    <= ins_pos_next;
            last_reg       <= last_next;
            head_reg       <= head_next;
            sum_reg        <= sum_next;
            end_done_reg   <= end_done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        val_reg      <= val_next;
        pend_cyl_reg <= pend_cyl_next;
        pend_sum_reg <= pend_sum_next;
        out_cyl_reg  <= out_cyl_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = out_valid_reg;
    assign m_visited_cylinder = out_cyl_reg;
    assign m_seek_total       = out_sum_reg;
    assign m_last_visit       = out_last_reg;

    // Checks on the sequencer.
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("visit still pending while the scheduler is idle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("request count beyond store depth");

    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_request) |=> (state_reg != S_IDLE))
        else $error("final request word did not start service");

    a_end_stop_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(end_done_reg) |-> ($past(state_reg) == S_EV || $past(state_reg) == S_TOP))
        else $error("top end stop marked outside the upward sweep");

endmodule

`default_nettype wire
